// ----- src/pbm_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the pixel background model.
// Used by pixel_background_model; has no dependencies of its own.
package pbm_pkg;

  localparam int FRAME_PIXELS  = 65536;
  localparam int FRACTION_BITS = 8;
  localparam int CHANNELS      = 3;

  localparam int SAMPLE_W = 8;
  localparam int INDEX_W  = 16;
  localparam int RATE_W   = 16;
  localparam int MARGIN_W = 8;
  localparam int VAL_W    = 24;
  localparam int XF_W     = SAMPLE_W + FRACTION_BITS;
  localparam int POS_W    = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int WORD_W   = CHANNELS * VAL_W;

  // Deviation floor(sqrt(2) * d) is formed as floor(d * K / 2^SHIFT) and then
  // corrected upward by at most one.
  localparam int SQRT2_SHIFT = 25;
  localparam int K_W         = 26;
  localparam logic [K_W-1:0] SQRT2_K = K_W'(47453132);

  localparam int DD_W    = 2 * VAL_W;
  localparam int P_W     = VAL_W + K_W;
  localparam int R_W     = VAL_W + 1;
  localparam int RSQ_W   = 2 * R_W;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int BL_W    = DIFF_W + RATE_W + 1;
  localparam int SC_W    = VAL_W + RATE_W;
  localparam int BOUND_W = VAL_W + 2;
  localparam int STAGES  = 7;

  localparam logic [1:0] OP_MEAN   = 2'd0;
  localparam logic [1:0] OP_DEV    = 2'd1;
  localparam logic [1:0] OP_DETECT = 2'd2;

  localparam logic [1:0] MARK_FIRST = 2'd1;
  localparam logic [1:0] MARK_LAST  = 2'd2;

  localparam logic [1:0] REG_INIT_SCALE = 2'd0;
  localparam logic [1:0] REG_BG_RATE    = 2'd1;
  localparam logic [1:0] REG_OBJ_RATE   = 2'd2;
  localparam logic [1:0] REG_MARGIN     = 2'd3;

  localparam logic [RATE_W-1:0]   INIT_SCALE_RESET = RATE_W'(1311);
  localparam logic [RATE_W-1:0]   BG_RATE_RESET    = RATE_W'(1311);
  localparam logic [RATE_W-1:0]   OBJ_RATE_RESET   = RATE_W'(328);
  localparam logic [MARGIN_W-1:0] MARGIN_RESET     = MARGIN_W'(10);

  typedef logic [CHANNELS-1:0][VAL_W-1:0] vals_t;

  typedef struct packed {
    logic [1:0]                         op;
    logic [1:0]                         mark;
    logic [INDEX_W-1:0]                 index;
    logic [POS_W-1:0]                   pos;
    logic                               bg;
    logic [CHANNELS-1:0][SAMPLE_W-1:0]  x;
  } tag_t;

endpackage

// ----- src/pbm_ram.sv -----
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/pixel_background_model.sv -----
`timescale 1ns / 1ps
// Per-pixel RGB background model: seven-stage read-modify-write pipeline
// around a mean memory and a spread memory. Depends on pbm_pkg and pbm_ram.
// Throughput: one request per cycle while the output is not stalled; a
// request waits while an earlier request for the same pixel is still inside
// the seven stages between read and write.
// Reset clears the registers to their defaults and empties the pipeline; the
// memories are not cleared.
module pixel_background_model (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [pbm_pkg::RATE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [1:0]                    frame_mark,
  input  logic [pbm_pkg::INDEX_W-1:0]   pixel_index,
  input  logic [pbm_pkg::SAMPLE_W-1:0]  red,
  input  logic [pbm_pkg::SAMPLE_W-1:0]  green,
  input  logic [pbm_pkg::SAMPLE_W-1:0]  blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pbm_pkg::INDEX_W-1:0]   out_index,
  output logic                          is_background
);
  import pbm_pkg::*;

  logic [RATE_W-1:0]   init_scale;
  logic [RATE_W-1:0]   background_rate;
  logic [RATE_W-1:0]   object_rate;
  logic [MARGIN_W-1:0] margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_scale      <= INIT_SCALE_RESET;
      background_rate <= BG_RATE_RESET;
      object_rate     <= OBJ_RATE_RESET;
      margin          <= MARGIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INIT_SCALE: init_scale      <= cfg_data;
        REG_BG_RATE:    background_rate <= cfg_data;
        REG_OBJ_RATE:   object_rate     <= cfg_data;
        REG_MARGIN:     margin          <= cfg_data[MARGIN_W-1:0];
        default:        ;
      endcase
    end
  end

  function automatic logic [VAL_W-1:0] xf_of(input logic [SAMPLE_W-1:0] s);
    return VAL_W'({s, {FRACTION_BITS{1'b0}}});
  endfunction

  logic [STAGES:1] v;
  logic [STAGES:1] move;
  logic [STAGES:1] free;
  tag_t            tag    [1:STAGES];
  tag_t            tag_in [1:STAGES];
  logic            out_free;
  logic            hazard;
  logic            in_accept;
  logic [POS_W-1:0] in_pos;

  assign in_pos = POS_W'(pixel_index & INDEX_W'(FRAME_PIXELS - 1));
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    move[STAGES] = v[STAGES] && out_free;
    free[STAGES] = !v[STAGES] || move[STAGES];
    for (int k = STAGES - 1; k >= 1; k--) begin
      move[k] = v[k] && free[k+1];
      free[k] = !v[k] || move[k];
    end
  end

  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= STAGES; k++) begin
      if (v[k] && tag[k].pos == in_pos) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall  = !free[1] || hazard;
  assign in_accept = in_valid && !in_stall;

  vals_t mean_q;
  vals_t spread_q;
  logic  mean_we;
  logic  spread_we;
  vals_t mean_wdata;
  vals_t spread_wdata;

  pbm_ram #(.WIDTH(WORD_W), .DEPTH(FRAME_PIXELS)) u_mean_ram (
    .clk   (clk),
    .we    (mean_we),
    .waddr (tag[STAGES].pos),
    .wdata (mean_wdata),
    .re    (in_accept),
    .raddr (in_pos),
    .rdata (mean_q)
  );

  pbm_ram #(.WIDTH(WORD_W), .DEPTH(FRAME_PIXELS)) u_spread_ram (
    .clk   (clk),
    .we    (spread_we),
    .waddr (tag[STAGES].pos),
    .wdata (spread_wdata),
    .re    (in_accept),
    .raddr (in_pos),
    .rdata (spread_q)
  );

  // Stage 1: distance to the mean and the background test.
  logic                                bg1;
  logic [CHANNELS-1:0][VAL_W-1:0]      d1;

  always_comb begin
    logic [VAL_W-1:0]   xf;
    logic [BOUND_W-1:0] ext;
    logic [CHANNELS-1:0] inr;
    for (int c = 0; c < CHANNELS; c++) begin
      xf  = xf_of(tag[1].x[c]);
      ext = BOUND_W'(spread_q[c]) + BOUND_W'({margin, {FRACTION_BITS{1'b0}}});
      d1[c] = (xf > mean_q[c]) ? xf - mean_q[c] : mean_q[c] - xf;
      inr[c] = (BOUND_W'(mean_q[c]) <= BOUND_W'(xf) + ext) &&
               (BOUND_W'(xf) < BOUND_W'(mean_q[c]) + ext);
    end
    bg1 = (tag[1].op == OP_DETECT) && (&inr);
  end

  always_comb begin
    tag_in[1] = '{op: op, mark: frame_mark, index: pixel_index, pos: in_pos,
                  bg: 1'b0, x: {blue, green, red}};
    tag_in[2] = tag[1];
    tag_in[2].bg = bg1;
    for (int k = 3; k <= STAGES; k++) begin
      tag_in[k] = tag[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= STAGES; k++) begin
        if ((k == 1) ? in_accept : move[k-1]) begin
          v[k] <= 1'b1;
        end else if (move[k]) begin
          v[k] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= STAGES; k++) begin
      if ((k == 1) ? in_accept : move[k-1]) begin
        tag[k] <= tag_in[k];
      end
    end
  end

  // Stages 2 to 4: deviation floor(sqrt(2) * d), saturated.
  vals_t                          mean_p   [2:6];
  vals_t                          spread_p [2:6];
  vals_t                          d_r2;
  logic [CHANNELS-1:0][P_W-1:0]   p_r3;
  logic [CHANNELS-1:0][DD_W-1:0]  dd_r3;
  logic [CHANNELS-1:0][DD_W-1:0]  dd_r4;
  logic [CHANNELS-1:0][R_W-1:0]   r0_r4;
  logic [CHANNELS-1:0][RSQ_W-1:0] rsq_r4;
  vals_t                          dev_r5;

  logic [CHANNELS-1:0][P_W-1:0]   p2;
  logic [CHANNELS-1:0][DD_W-1:0]  dd2;
  logic [CHANNELS-1:0][RSQ_W-1:0] rsq3;
  vals_t                          dev4;

  always_comb begin
    logic [R_W-1:0] r1;
    logic [R_W-1:0] r;
    for (int c = 0; c < CHANNELS; c++) begin
      p2[c]   = P_W'(d_r2[c]) * P_W'(SQRT2_K);
      dd2[c]  = DD_W'(d_r2[c]) * DD_W'(d_r2[c]);
      r1      = p_r3[c][SQRT2_SHIFT +: R_W] + R_W'(1);
      rsq3[c] = RSQ_W'(r1) * RSQ_W'(r1);
      r       = (rsq_r4[c] <= RSQ_W'({dd_r4[c], 1'b0})) ? r0_r4[c] + R_W'(1) : r0_r4[c];
      dev4[c] = r[R_W-1] ? {VAL_W{1'b1}} : r[VAL_W-1:0];
    end
  end

  // Stage 5: accumulation sums, or the rate products of the running average.
  vals_t                 sum5;
  logic signed [BL_W-1:0] pm5 [CHANNELS];
  logic signed [BL_W-1:0] ps5 [CHANNELS];

  always_comb begin
    logic [VAL_W-1:0]         term;
    logic [VAL_W-1:0]         old;
    logic [VAL_W:0]           s;
    logic signed [DIFF_W-1:0] dm;
    logic signed [DIFF_W-1:0] ds;
    logic [RATE_W-1:0]        rate;
    rate = tag[5].bg ? background_rate : object_rate;
    for (int c = 0; c < CHANNELS; c++) begin
      term = (tag[5].op == OP_MEAN) ? xf_of(tag[5].x[c]) : dev_r5[c];
      old  = (tag[5].op == OP_MEAN) ? mean_p[5][c] : spread_p[5][c];
      s    = {1'b0, old} + {1'b0, term};
      if (tag[5].mark == MARK_FIRST) begin
        sum5[c] = term;
      end else begin
        sum5[c] = s[VAL_W] ? {VAL_W{1'b1}} : s[VAL_W-1:0];
      end
      dm = $signed({1'b0, xf_of(tag[5].x[c])}) - $signed({1'b0, mean_p[5][c]});
      ds = $signed({1'b0, dev_r5[c]}) - $signed({1'b0, spread_p[5][c]});
      pm5[c] = dm * $signed({1'b0, background_rate});
      ps5[c] = ds * $signed({1'b0, rate});
    end
  end

  // Stage 6: phase scaling product, or rounding of the running average.
  vals_t                            sum_r6;
  logic signed [BL_W-1:0]           pm_r6 [CHANNELS];
  logic signed [BL_W-1:0]           ps_r6 [CHANNELS];
  logic [CHANNELS-1:0][SC_W-1:0]    prod6;
  vals_t                            nm6;
  vals_t                            ns6;

  always_comb begin
    logic signed [BL_W:0]    rm;
    logic signed [BL_W:0]    rs;
    logic signed [VAL_W+2:0] tm;
    logic signed [VAL_W+2:0] ts;
    for (int c = 0; c < CHANNELS; c++) begin
      prod6[c] = SC_W'(sum_r6[c]) * SC_W'(init_scale);
      rm = (BL_W + 1)'(pm_r6[c]) + (BL_W + 1)'(32768);
      rs = (BL_W + 1)'(ps_r6[c]) + (BL_W + 1)'(32768);
      tm = $signed({3'b000, mean_p[6][c]}) + (VAL_W + 3)'(rm >>> RATE_W);
      ts = $signed({3'b000, spread_p[6][c]}) + (VAL_W + 3)'(rs >>> RATE_W);
      nm6[c] = tm[VAL_W-1:0];
      ns6[c] = ts[VAL_W-1:0];
    end
  end

  // Stage 7: final value and write-back.
  vals_t                         sum_r7;
  logic [CHANNELS-1:0][SC_W-1:0] prod_r7;
  vals_t                         nm_r7;
  vals_t                         ns_r7;
  vals_t                         acc7;

  always_comb begin
    logic [SC_W:0] rounded;
    for (int c = 0; c < CHANNELS; c++) begin
      rounded = {1'b0, prod_r7[c]} + (SC_W + 1)'(32768);
      acc7[c] = (tag[STAGES].mark == MARK_LAST) ? rounded[RATE_W +: VAL_W] : sum_r7[c];
    end
  end

  assign mean_we = move[STAGES] && ((tag[STAGES].op == OP_MEAN) ||
                   (tag[STAGES].op == OP_DETECT && tag[STAGES].bg));
  assign spread_we = move[STAGES] && ((tag[STAGES].op == OP_DEV) ||
                     (tag[STAGES].op == OP_DETECT));
  assign mean_wdata   = (tag[STAGES].op == OP_MEAN) ? acc7 : nm_r7;
  assign spread_wdata = (tag[STAGES].op == OP_DEV) ? acc7 : ns_r7;

  always_ff @(posedge clk) begin
    if (move[1]) begin
      mean_p[2]   <= mean_q;
      spread_p[2] <= spread_q;
      d_r2        <= d1;
    end
    if (move[2]) begin
      mean_p[3]   <= mean_p[2];
      spread_p[3] <= spread_p[2];
      p_r3        <= p2;
      dd_r3       <= dd2;
    end
    if (move[3]) begin
      mean_p[4]   <= mean_p[3];
      spread_p[4] <= spread_p[3];
      dd_r4       <= dd_r3;
      rsq_r4      <= rsq3;
      for (int c = 0; c < CHANNELS; c++) begin
        r0_r4[c] <= p_r3[c][SQRT2_SHIFT +: R_W];
      end
    end
    if (move[4]) begin
      mean_p[5]   <= mean_p[4];
      spread_p[5] <= spread_p[4];
      dev_r5      <= dev4;
    end
    if (move[5]) begin
      mean_p[6]   <= mean_p[5];
      spread_p[6] <= spread_p[5];
      sum_r6      <= sum5;
      pm_r6       <= pm5;
      ps_r6       <= ps5;
    end
    if (move[6]) begin
      sum_r7  <= sum_r6;
      prod_r7 <= prod6;
      nm_r7   <= nm6;
      ns_r7   <= ns6;
    end
    if (move[STAGES]) begin
      out_index     <= tag[STAGES].index;
      is_background <= tag[STAGES].bg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move[STAGES]) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // A memory write never lands on the pixel that is being read in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (mean_we || spread_we) && in_accept |-> tag[STAGES].pos != in_pos)
    else $error("write and read of the same pixel in one cycle");

  // A blocked last stage keeps its request and its write back pending.
  a_last_stage_holds: assert property (@(posedge clk) disable iff (rst)
    v[STAGES] && !move[STAGES] |=> v[STAGES] && $stable(tag[STAGES]))
    else $error("last stage lost its request while blocked");

  // A new result only appears after the last stage handed one over.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(move[STAGES]))
    else $error("result appeared without a write-back stage transfer");

endmodule
